[design/seven_bit_frame_receiver_top_defines.svh]
// Assertion macros used by the frame receiver checker.
`ifndef SEVEN_BIT_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SEVEN_BIT_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/frx_pkg.sv]
// Shared types and constants of the seven-bit frame receiver.
package frx_pkg;

  localparam int BYTE_W = 8;
  localparam int DATA_W = 7;
  localparam int LEN_W  = 6;
  localparam int GRP_W  = 3;

  localparam logic [BYTE_W-1:0] BEGIN_BYTE = 8'hD4;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h81;
  localparam int                TOP_BIT    = 7;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

  // Work handed from the front to the back.
  typedef struct packed {
    logic             is_err;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // Store read request issued by the back.
  typedef struct packed {
    logic [LEN_W-1:0] pay_addr;
    logic [LEN_W-1:0] tail_addr;
  } rd_req_t;

  // Store read data returned to the back.
  typedef struct packed {
    logic [DATA_W-1:0] pay;
    logic [DATA_W-1:0] tail;
  } rd_data_t;

endpackage

[design/frx_front.sv]
// Front: byte classification, frame store and command generation.
module frx_front import frx_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              push_o,
  output cmd_t              push_cmd_o,
  input  logic              q_full_i,
  input  logic              frame_done_i,
  input  rd_req_t           rd_req_i,
  output rd_data_t          rd_data_o
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [DATA_W-1:0] mem [BUF_DEPTH];

  logic          receiving_q, receiving_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          accept;
  logic          wr_en;

  logic [LEN_W-1:0] len_l;
  logic [LEN_W:0]   tail_sum;
  logic [LEN_W-1:0] frame_n;

  assign in_stall_o = q_full_i || pend_q;
  assign accept     = in_valid_i && !in_stall_o;

  // n = L - ceil(L/8)
  assign len_l    = LEN_W'(cnt_q);
  assign tail_sum = ({1'b0, len_l} + (LEN_W+1)'(7)) >> 3;
  assign frame_n  = len_l - tail_sum[LEN_W-1:0];

  always_comb begin
    receiving_d = receiving_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q && !frame_done_i;
    push_o      = 1'b0;
    push_cmd_o  = '{is_err: 1'b0, len: frame_n};
    wr_en       = 1'b0;
    if (accept) begin
      if (!receiving_q) begin
        if (rx_byte_i == BEGIN_BYTE) begin
          receiving_d = 1'b1;
          cnt_d       = '0;
        end
      end else if (rx_byte_i[TOP_BIT]) begin
        cnt_d = '0;
        if (rx_byte_i == END_BYTE) begin
          receiving_d = 1'b0;
          if (frame_n != '0) begin
            push_o = 1'b1;
            pend_d = 1'b1;
          end
        end else if (rx_byte_i == BEGIN_BYTE) begin
          receiving_d = 1'b1;
        end else begin
          receiving_d = 1'b0;
          push_o      = 1'b1;
          push_cmd_o  = '{is_err: 1'b1, len: '0};
        end
      end else begin
        wr_en = 1'b1;
        if (cnt_q == AW'(BUF_DEPTH - 1)) begin
          // overflow: drop the frame
          receiving_d = 1'b0;
          cnt_d       = '0;
          push_o      = 1'b1;
          push_cmd_o  = '{is_err: 1'b1, len: '0};
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
    end else begin
      receiving_q <= receiving_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q] <= rx_byte_i[DATA_W-1:0];
    end
    rd_data_o.pay  <= mem[rd_req_i.pay_addr[AW-1:0]];
    rd_data_o.tail <= mem[rd_req_i.tail_addr[AW-1:0]];
  end

endmodule

[design/frx_cmd_fifo.sv]
// Two-entry command queue between front and back.
module frx_cmd_fifo import frx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam logic [1:0] DEPTH = 2'd2;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == DEPTH);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[design/frx_back.sv]
// Back: frame decode sequencer and output register.
module frx_back import frx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              q_head_i,
  output logic              pop_o,
  output rd_req_t           rd_req_o,
  input  rd_data_t          rd_data_i,
  output logic              frame_done_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic              last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_ERR
  } state_e;

  state_e           state_q;
  logic [LEN_W-1:0] n_q;
  logic [LEN_W-1:0] idx_q;
  logic [GRP_W-1:0] grp_q;
  logic [GRP_W-1:0] bit_q;
  logic             slot_free;
  logic             is_last;
  logic             top_bit;

  assign slot_free = !out_valid_o || !out_stall_i;
  assign pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign is_last   = (idx_q == n_q - LEN_W'(1));
  assign top_bit   = rd_data_i.tail[bit_q];

  assign rd_req_o.pay_addr  = idx_q;
  assign rd_req_o.tail_addr = n_q + LEN_W'(grp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      n_q            <= '0;
      idx_q          <= '0;
      grp_q          <= '0;
      bit_q          <= '0;
      frame_done_o   <= 1'b0;
      out_valid_o    <= 1'b0;
      kind_o         <= KIND_DATA;
      payload_byte_o <= '0;
      frame_length_o <= '0;
      last_o         <= 1'b0;
    end else begin
      frame_done_o <= 1'b0;
      if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            n_q   <= q_head_i.len;
            idx_q <= '0;
            grp_q <= '0;
            bit_q <= '0;
            state_q <= q_head_i.is_err ? S_ERR : S_RD;
          end
        end
        S_RD: begin
          // store data for idx_q arrives next cycle
          state_q <= S_LD;
        end
        S_LD: begin
          if (slot_free) begin
            out_valid_o    <= 1'b1;
            kind_o         <= KIND_DATA;
            payload_byte_o <= {top_bit, rd_data_i.pay};
            frame_length_o <= n_q;
            last_o         <= is_last;
            if (is_last) begin
              frame_done_o <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              idx_q <= idx_q + LEN_W'(1);
              if (bit_q == GRP_W'(6)) begin
                bit_q <= '0;
                grp_q <= grp_q + GRP_W'(1);
              end else begin
                bit_q <= bit_q + GRP_W'(1);
              end
              state_q <= S_RD;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_valid_o    <= 1'b1;
            kind_o         <= KIND_ERR;
            payload_byte_o <= '0;
            frame_length_o <= '0;
            last_o         <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/seven_bit_frame_receiver_top.sv]
// Top level of the seven-bit frame receiver.
// Input channel: one line byte per transfer on rx_byte_i (in_valid_i/in_stall_o).
// Byte 0xD4 opens a frame, bytes below 0x80 are stored, 0x81 closes it.
// Output channel: one decoded byte or error per transfer (out_valid_o/out_stall_i),
// with kind_o, payload_byte_o, frame_length_o and last_o.
// A data byte or marker is taken whenever in_stall_o is low. After an end byte
// the back decodes the frame one payload byte at a time: a two-port store read
// (payload and tail byte), then a load of the output register, which waits while
// the output stalls. The end byte's command passes through the command queue first.
// While a frame is being decoded the input stalls, since the frame store is
// still being read; error results queue up in a two-entry command queue.
// An output stall holds the output register and the decode sequencer; the
// front keeps taking bytes until the command queue fills or a data frame is pending.
// Reset clears the receive state, queue and output valid; the store itself
// is not cleared, and no clearing pass is needed.
module seven_bit_frame_receiver_top import frx_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic              last_o
);

  logic     push;
  cmd_t     push_cmd;
  logic     q_full;
  logic     q_valid;
  cmd_t     q_head;
  logic     pop;
  logic     frame_done;
  rd_req_t  rd_req;
  rd_data_t rd_data;

  frx_front #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .q_full_i    (q_full),
    .frame_done_i(frame_done),
    .rd_req_i    (rd_req),
    .rd_data_o   (rd_data)
  );

  frx_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  frx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .pop_o         (pop),
    .rd_req_o      (rd_req),
    .rd_data_i     (rd_data),
    .frame_done_o  (frame_done),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_length_o(frame_length_o),
    .last_o        (last_o)
  );

endmodule

[design/frx_checker.sv]
// Port-level checker of the frame receiver and its bind.
`include "seven_bit_frame_receiver_top_defines.svh"

module frx_checker import frx_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              kind_o,
  input logic [BYTE_W-1:0] payload_byte_o,
  input logic [LEN_W-1:0]  frame_length_o,
  input logic              last_o
);

  `FRX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i, out_valid_o, "output dropped while stalled")

  `FRX_ASSERT_NEXT(a_out_stable, clk_i, rst_ni,
    out_valid_o && out_stall_i, $stable(payload_byte_o) && $stable(kind_o),
    "stalled output changed")

  `FRX_ASSERT_IMPL(a_err_form, clk_i, rst_ni,
    out_valid_o && kind_o == KIND_ERR,
    payload_byte_o == '0 && frame_length_o == '0 && last_o, "malformed error result")

  `FRX_ASSERT_IMPL(a_data_len, clk_i, rst_ni,
    out_valid_o && kind_o == KIND_DATA, frame_length_o != '0,
    "data result with zero frame length")

endmodule

bind seven_bit_frame_receiver_top frx_checker u_frx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .payload_byte_o(payload_byte_o),
  .frame_length_o(frame_length_o),
  .last_o        (last_o)
);

[tb/seven_bit_frame_receiver_top_tb.sv]
// Self-checking testbench for the seven-bit frame receiver: decode prediction and result checks.
module seven_bit_frame_receiver_top_tb;
  import frx_pkg::*;

  localparam int DEPTH        = 64;
  localparam int HOLD_CYCLES  = 250;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] payload;
    logic [LEN_W-1:0]  length;
    logic              last;
  } frame_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              kind_o;
  logic [BYTE_W-1:0] payload_byte_o;
  logic [LEN_W-1:0]  frame_length_o;
  logic              last_o;

  // Predictor state
  logic              in_frame = 1'b0;
  int unsigned       held_count = 0;
  logic [6:0]        line_store [DEPTH];
  frame_result_t     decoded_queue [$];

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       bytes_counted = 0;
  int unsigned       fail_count = 0;
  int unsigned       quiet_cycles = 0;
  logic              hold_req = 1'b0;
  logic              hold_ack = 1'b0;
  int unsigned       hold_left = 0;

  seven_bit_frame_receiver_top #(.BUF_DEPTH(DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_frame_error();
    frame_result_t r;
    r.kind    = KIND_ERR;
    r.payload = '0;
    r.length  = '0;
    r.last    = 1'b1;
    decoded_queue.push_back(r);
  endfunction

  // Track the frame state and queue the results one accepted line byte causes.
  function automatic void absorb_line_byte(input logic [BYTE_W-1:0] b);
    int unsigned   tails;
    int unsigned   n;
    int unsigned   ti;
    frame_result_t r;
    if (!in_frame) begin
      if (b == BEGIN_BYTE) begin
        in_frame   = 1'b1;
        held_count = 0;
      end
      return;
    end
    if (b[TOP_BIT]) begin
      if (b == END_BYTE) begin
        tails = (held_count + 7) / 8;
        n     = held_count - tails;
        for (int unsigned i = 0; i < n; i++) begin
          ti        = n + i / 7;
          r.kind    = KIND_DATA;
          r.payload = {line_store[ti][i % 7], line_store[i]};
          r.length  = LEN_W'(n);
          r.last    = (i + 1 == n);
          decoded_queue.push_back(r);
        end
        in_frame   = 1'b0;
        held_count = 0;
      end else if (b == BEGIN_BYTE) begin
        held_count = 0;
      end else begin
        in_frame   = 1'b0;
        held_count = 0;
        push_frame_error();
      end
    end else begin
      line_store[held_count] = b[6:0];
      held_count++;
      if (held_count >= DEPTH) begin
        in_frame   = 1'b0;
        held_count = 0;
        push_frame_error();
      end
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    if (in_frame || b == BEGIN_BYTE) bytes_counted++;
    absorb_line_byte(b);
  endtask

  function automatic logic [BYTE_W-1:0] rand_data();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return BYTE_W'($urandom_range(127));
    endcase
  endfunction

  task automatic send_frame(input int unsigned len);
    send_byte(BEGIN_BYTE);
    repeat (len) send_byte(rand_data());
    send_byte(END_BYTE);
  endtask

  task automatic set_idling(input int unsigned snd, input int unsigned rcv);
    send_idle_pct  = snd;
    recv_idle_pct <= rcv;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    fail_count++;
  endtask

  task automatic test_directed_cases();
    // noise while waiting
    send_byte(8'hFF);
    send_byte(8'h80);
    // empty and one-byte frames give nothing
    send_byte(BEGIN_BYTE);
    send_byte(END_BYTE);
    send_byte(BEGIN_BYTE);
    send_byte(8'h7F);
    send_byte(END_BYTE);
    // restart inside a frame, then two-byte frames with the top bit set and clear
    send_byte(BEGIN_BYTE);
    send_byte(8'h2A);
    send_byte(BEGIN_BYTE);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(END_BYTE);
    send_byte(BEGIN_BYTE);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(END_BYTE);
    // stray markers abort the frame
    send_byte(BEGIN_BYTE);
    send_byte(8'h33);
    send_byte(8'hFF);
    send_byte(BEGIN_BYTE);
    send_byte(8'h80);
  endtask

  task automatic test_frame_extremes();
    send_frame(DEPTH - 1);
    send_byte(BEGIN_BYTE);
    repeat (DEPTH) send_byte(rand_data());
  endtask

  task automatic test_random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = bytes_counted;
    while (bytes_counted - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame($urandom_range(16));
      end else if (pick < 64) begin
        send_frame($urandom_range(40, DEPTH - 1));
      end else if (pick < 67) begin
        send_byte(BEGIN_BYTE);
        repeat (DEPTH) send_byte(rand_data());
      end else if (pick < 80) begin
        // random marker after a few bytes; breaks the frame unless it is a begin or end byte
        send_byte(BEGIN_BYTE);
        repeat ($urandom_range(6)) send_byte(rand_data());
        send_byte(BYTE_W'($urandom_range(128, 255)));
      end else if (pick < 90) begin
        send_frame($urandom_range(10));
        send_byte(BYTE_W'($urandom_range(255)));
      end else begin
        send_byte(BEGIN_BYTE);
        repeat ($urandom_range(5)) send_byte(rand_data());
        send_frame($urandom_range(12));
      end
    end
  endtask

  task automatic test_output_hold();
    hold_req <= ~hold_req;
    send_frame(20);
    repeat (4) begin
      send_byte(BEGIN_BYTE);
      send_byte(BYTE_W'($urandom_range(128, 255)));
    end
    send_frame(10);
  endtask

  // Receiver side: random stall plus a long hold on request.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each output transfer with the oldest expected result.
  always @(negedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d byte=%02h len=%0d last=%0d",
                                  kind_o, payload_byte_o, frame_length_o, last_o));
      end else begin
        want = decoded_queue.pop_front();
        if (kind_o !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
        if (payload_byte_o !== want.payload)
          report_mismatch($sformatf("payload_byte %02h, want %02h",
                                    payload_byte_o, want.payload));
        if (frame_length_o !== want.length)
          report_mismatch($sformatf("frame_length %0d, want %0d",
                                    frame_length_o, want.length));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", last_o, want.last));
      end
    end
  end

  // Watchdog: end the run after too long without any transfer.
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        report_mismatch($sformatf("timeout with %0d results outstanding",
                                  decoded_queue.size()));
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_frame_extremes();
    set_idling(21, 85);
    test_random_traffic(10);
    set_idling(85, 21);
    test_random_traffic(10);
    set_idling(0, 0);
    test_output_hold();
    test_random_traffic(10);
    in_valid_i <= 1'b0;
    while (decoded_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[seven_bit_frame_receiver_top.f]
+incdir+design
design/frx_pkg.sv
design/frx_front.sv
design/frx_cmd_fifo.sv
design/frx_back.sv
design/seven_bit_frame_receiver_top.sv
design/frx_checker.sv
tb/seven_bit_frame_receiver_top_tb.sv
